@@ hdl/swdbe_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the serial wire debug master bit engine.
// Used by the front end, the command queue, the pulse sequencer and the top level.
package swdbe_pkg;

	localparam int DATA_W       = 32;
	localparam int CNT_W        = 6;
	localparam int IDX_W        = 5;
	localparam int HP_W         = 8;
	localparam int TMR_W        = HP_W + 1;
	localparam int MAX_BITS_DEF = 32;
	localparam int QDEPTH_DEF   = 2;

	// Command codes.
	localparam logic [1:0] CMD_WR     = 2'd0;
	localparam logic [1:0] CMD_WR_PAR = 2'd1;
	localparam logic [1:0] CMD_RD     = 2'd2;
	localparam logic [1:0] CMD_RD_PAR = 2'd3;

	// Pulse kinds reported with each result.
	localparam logic [1:0] KIND_TURN  = 2'd0;
	localparam logic [1:0] KIND_DATA  = 2'd1;
	localparam logic [1:0] KIND_PAR   = 2'd2;
	localparam logic [1:0] KIND_NONE  = 2'd3;

	// A classified command, as it travels from the front end to the sequencer.
	typedef struct packed {
		logic              writing;
		logic              with_par;
		logic              pre_ta;
		logic [CNT_W-1:0]  count;
		logic [DATA_W-1:0] out_data;
		logic              par_out;
		logic [DATA_W-1:0] word;
		logic              good;
	} desc_t;

	// Queue status seen by the two sides.
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

@@ hdl/swdbe_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts command items, tracks the SWDIO direction and classifies each item.
// Depends on swdbe_pkg.
module swdbe_front import swdbe_pkg::*; #(
	parameter int MAX_BITS = MAX_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        cmd,
	input  logic [CNT_W-1:0]  bit_count,
	input  logic [DATA_W-1:0] out_data,
	input  logic [DATA_W-1:0] line_data,
	input  logic              line_parity,
	input  q_stat_t           q_stat,
	output logic              q_push,
	output desc_t             q_desc
);

	localparam int LIMIT = (MAX_BITS < DATA_W) ? MAX_BITS : DATA_W;

	logic              dir_q;
	logic              writing;
	logic              with_par;
	logic [CNT_W-1:0]  count;
	logic [DATA_W-1:0] mask;
	logic [DATA_W-1:0] word;

	assign in_ready = !q_stat.full;
	assign q_push   = in_valid && in_ready;

	assign writing  = (cmd == CMD_WR) || (cmd == CMD_WR_PAR);
	assign with_par = (cmd == CMD_WR_PAR) || (cmd == CMD_RD_PAR);
	assign count    = (bit_count > CNT_W'(LIMIT)) ? CNT_W'(LIMIT) : bit_count;

	always_comb begin
		for (int i = 0; i < DATA_W; i++) begin
			mask[i] = (CNT_W'(i) < count);
		end
	end

	assign word = line_data & mask;

	always_comb begin
		q_desc.writing  = writing;
		q_desc.with_par = with_par;
		q_desc.pre_ta   = writing ? !dir_q : dir_q;
		q_desc.count    = count;
		q_desc.out_data = out_data;
		q_desc.par_out  = ^out_data;
		q_desc.word     = writing ? '0 : word;
		q_desc.good     = (!writing && with_par) ? (line_parity == ^word) : 1'b0;
	end

	// A read with parity hands the line back to the host at its end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= 1'b0;
		end else if (q_push) begin
			dir_q <= writing || with_par;
		end
	end

endmodule

@@ hdl/swdbe_queue.sv @@
`timescale 1ns / 1ps
// Short queue of classified commands between the front end and the sequencer.
// Depends on swdbe_pkg.
module swdbe_queue import swdbe_pkg::*; #(
	parameter int DEPTH = QDEPTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  desc_t   push_desc,
	input  logic    pop,
	output desc_t   pop_desc,
	output q_stat_t stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_QW = $clog2(DEPTH + 1);

	desc_t              mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_QW-1:0]  fill_q;

	assign stat.full  = (fill_q == CNT_QW'(DEPTH));
	assign stat.empty = (fill_q == '0);
	assign pop_desc   = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				fill_q <= fill_q + CNT_QW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - CNT_QW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty) else $error("queue read while empty");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_QW'(DEPTH)) else $error("queue fill count out of range");

endmodule

@@ hdl/swdbe_back.sv @@
`timescale 1ns / 1ps
// Pulse sequencer: walks one classified command through its SWCLK pulses,
// paces them by the half period register and delivers one result per pulse. Uses swdbe_pkg.
module swdbe_back import swdbe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [HP_W-1:0]   cfg_wdata,
	input  q_stat_t           q_stat,
	input  desc_t             q_desc,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        pulse_kind,
	output logic              swdio_driven,
	output logic              swdio_level,
	output logic [DATA_W-1:0] read_word,
	output logic              parity_good,
	output logic              last
);

	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_TA_PRE  = 3'd1;
	localparam logic [2:0] PH_DATA    = 3'd2;
	localparam logic [2:0] PH_PAR     = 3'd3;
	localparam logic [2:0] PH_TA_POST = 3'd4;
	localparam logic [2:0] PH_NONE    = 3'd5;

	logic [HP_W-1:0]   half_period_q;
	logic [2:0]        phase_q;
	logic [IDX_W-1:0]  idx_q;
	logic [TMR_W-1:0]  timer_q;
	desc_t             desc_q;
	logic              out_valid_q;
	logic [1:0]        kind_q;
	logic              drv_q;
	logic              lvl_q;
	logic [DATA_W-1:0] word_q;
	logic              good_q;
	logic              last_q;

	logic              out_free;
	logic              emit;
	logic              idx_end;
	logic [2:0]        start_ph;
	logic [2:0]        nxt_ph;
	logic [1:0]        cur_kind;
	logic              cur_drv;
	logic              cur_lvl;
	logic              cur_last;

	assign out_free = !out_valid_q || out_ready;
	assign q_pop    = (phase_q == PH_IDLE) && !q_stat.empty;
	assign emit     = (phase_q != PH_IDLE) && (timer_q == '0) && out_free;
	assign idx_end  = (CNT_W'(idx_q) + CNT_W'(1)) == desc_q.count;

	// First pulse of a newly fetched command.
	always_comb begin
		if (q_desc.pre_ta) begin
			start_ph = PH_TA_PRE;
		end else if (q_desc.count != '0) begin
			start_ph = PH_DATA;
		end else if (q_desc.with_par) begin
			start_ph = PH_PAR;
		end else begin
			start_ph = PH_NONE;
		end
	end

	// The current pulse and the one that follows it.
	always_comb begin
		cur_kind = KIND_NONE;
		cur_drv  = 1'b0;
		cur_lvl  = 1'b0;
		nxt_ph   = PH_IDLE;
		case (phase_q)
			PH_TA_PRE: begin
				cur_kind = KIND_TURN;
				if (desc_q.count != '0) begin
					nxt_ph = PH_DATA;
				end else if (desc_q.with_par) begin
					nxt_ph = PH_PAR;
				end
			end
			PH_DATA: begin
				cur_kind = KIND_DATA;
				cur_drv  = desc_q.writing;
				cur_lvl  = desc_q.writing && desc_q.out_data[idx_q];
				if (!idx_end) begin
					nxt_ph = PH_DATA;
				end else if (desc_q.with_par) begin
					nxt_ph = PH_PAR;
				end
			end
			PH_PAR: begin
				cur_kind = KIND_PAR;
				cur_drv  = desc_q.writing;
				cur_lvl  = desc_q.writing && desc_q.par_out;
				if (!desc_q.writing) begin
					nxt_ph = PH_TA_POST;
				end
			end
			PH_TA_POST: begin
				cur_kind = KIND_TURN;
			end
			default: begin
				cur_kind = KIND_NONE;
			end
		endcase
		cur_last = (nxt_ph == PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= '0;
		end else if (cfg_we) begin
			half_period_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			idx_q       <= '0;
			timer_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				phase_q <= start_ph;
				idx_q   <= '0;
				timer_q <= {half_period_q, 1'b1};
			end else if (phase_q != PH_IDLE) begin
				if (timer_q != '0) begin
					timer_q <= timer_q - TMR_W'(1);
				end else if (out_free) begin
					phase_q <= nxt_ph;
					timer_q <= {half_period_q, 1'b1};
					if (phase_q == PH_DATA) begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			desc_q <= q_desc;
		end
		if (emit) begin
			kind_q <= cur_kind;
			drv_q  <= cur_drv;
			lvl_q  <= cur_lvl;
			last_q <= cur_last;
			word_q <= (cur_last && !desc_q.writing) ? desc_q.word : '0;
			good_q <= cur_last && !desc_q.writing && desc_q.good;
		end
	end

	assign out_valid    = out_valid_q;
	assign pulse_kind   = kind_q;
	assign swdio_driven = drv_q;
	assign swdio_level  = lvl_q;
	assign read_word    = word_q;
	assign parity_good  = good_q;
	assign last         = last_q;

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		emit && cur_last |=> phase_q == PH_IDLE) else $error("sequencer ran past last pulse");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> CNT_W'(idx_q) < desc_q.count)
		else $error("data index beyond bit count");
	a_none_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == KIND_NONE |-> last_q)
		else $error("no-clock result not marked last");
	a_float_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !drv_q |-> !lvl_q) else $error("level set on floating line");

endmodule

@@ hdl/swd_master_bit_engine.sv @@
`timescale 1ns / 1ps
// Top level of the serial wire debug master bit engine.
// Instantiates swdbe_front, swdbe_queue and swdbe_back; depends on swdbe_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one command item: cmd, bit_count,
//   out_data, and for reads the line_data/line_parity the target presents.
//   Output channel (out_valid/out_ready) carries one result item per SWCLK pulse,
//   with last set on the final result of each command. A command with no pulse
//   gives one no-clock result. The half period register is written through
//   cfg_we/cfg_wdata, by the user only while idle; the block does not enforce it.
// Timing:
//   Each pulse is paced in the pulse sequencer by the half period register,
//   and one timer paces every pulse of a command. A command of up to 35
//   pulses is fetched from the command queue before its first pulse. An
//   item accepted while the sequencer is idle is fetched in the cycle after
//   it is accepted, and its first result is registered once the timer loaded
//   at the fetch runs out and the output register is free. The front end
//   accepts a new item in any cycle in which the two-entry command queue has
//   room, so commands can be queued ahead.
// Reset:
//   arst_n clears the queue, the sequencer and the output valid flag, sets the
//   half period to zero and marks SWDIO as not driven in the front end.
// Stalls:
//   When out_ready is low the finished result holds in the output register and
//   the sequencer waits; the front end keeps accepting until the queue fills.
module swd_master_bit_engine import swdbe_pkg::*; #(
	parameter int MAX_BITS = MAX_BITS_DEF,
	parameter int QDEPTH   = QDEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [HP_W-1:0]   cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        cmd,
	input  logic [CNT_W-1:0]  bit_count,
	input  logic [DATA_W-1:0] out_data,
	input  logic [DATA_W-1:0] line_data,
	input  logic              line_parity,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        pulse_kind,
	output logic              swdio_driven,
	output logic              swdio_level,
	output logic [DATA_W-1:0] read_word,
	output logic              parity_good,
	output logic              last
);

	q_stat_t q_stat;
	logic    q_push;
	logic    q_pop;
	desc_t   push_desc;
	desc_t   pop_desc;

	// Front end: classifies commands and decides whether each starts with a turnaround.
	swdbe_front #(
		.MAX_BITS (MAX_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.bit_count   (bit_count),
		.out_data    (out_data),
		.line_data   (line_data),
		.line_parity (line_parity),
		.q_stat      (q_stat),
		.q_push      (q_push),
		.q_desc      (push_desc)
	);

	// Command queue between the two sides.
	swdbe_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_desc (push_desc),
		.pop       (q_pop),
		.pop_desc  (pop_desc),
		.stat      (q_stat)
	);

	// Pulse sequencer with the output register.
	swdbe_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.q_stat       (q_stat),
		.q_desc       (pop_desc),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pulse_kind   (pulse_kind),
		.swdio_driven (swdio_driven),
		.swdio_level  (swdio_level),
		.read_word    (read_word),
		.parity_good  (parity_good),
		.last         (last)
	);

endmodule
